// ===== design/uale_pkg.sv =====
// ----------------------------------------------------------------------------
// uale_pkg
// Shared operation codes, result codes and the command and status bundles
// that pass between the list controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package uale_pkg;

	typedef enum logic [2:0] {
		OP_PUT     = 3'd0,
		OP_GET     = 3'd1,
		OP_DEL     = 3'd2,
		OP_DEL_ALL = 3'd3,
		OP_EMPTY   = 3'd4,
		OP_CUR_RST = 3'd5,
		OP_NEXT    = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_ABSENT   = 2'd2,
		ST_PAST_END = 2'd3
	} status_t;

	typedef struct packed {
		logic start;
		logic put;
		logic scan_init;
		logic scan_step;
		logic scan_end;
		logic scan_resume;
		logic rm_rd;
		logic rm_wr;
		logic nx_rd;
		logic nx_cap;
		logic nx_miss;
		logic clear_all;
		logic cur_reset;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cursor_ok;
		logic scan_hit;
		logic scan_done;
		logic mv_match;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/uale_req_if.sv =====
// ----------------------------------------------------------------------------
// uale_req_if
// Request channel of the list engine: one operation with its key and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface uale_req_if #(
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              mode;
	logic [KEY_BITS-1:0]     key;
	logic [PAYLOAD_BITS-1:0] payload;

	modport source (output valid, output mode, output key, output payload, input ready);
	modport sink   (input valid, input mode, input key, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/uale_rsp_if.sv =====
// ----------------------------------------------------------------------------
// uale_rsp_if
// Response channel of the list engine: the returned entry plus list status.
// ----------------------------------------------------------------------------
`default_nettype none

interface uale_rsp_if #(
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32,
	parameter int CNT_W        = 7
) ();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [KEY_BITS-1:0]     item_key;
	logic [PAYLOAD_BITS-1:0] item_payload;
	logic [CNT_W-1:0]        entry_count;
	logic                    is_full;
	logic [1:0]              status;

	modport source (output valid, output found, output item_key, output item_payload,
		output entry_count, output is_full, output status, input ready);
	modport sink   (input valid, input found, input item_key, input item_payload,
		input entry_count, input is_full, input status, output ready);
endinterface

`default_nettype wire

// ===== design/uale_ram.sv =====
// ----------------------------------------------------------------------------
// uale_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module uale_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/uale_ctrl.sv =====
// ----------------------------------------------------------------------------
// uale_ctrl
// Operation sequencer: dispatches each request, steps the key scan and the
// move-last removals, and hands the result to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module uale_ctrl
	import uale_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_RM_RD  = 7'b0001000,
		S_RM_WR  = 7'b0010000,
		S_NX_CAP = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.op)
					OP_PUT: begin
						cmd.put = 1'b1;
						state_d = S_RESP;
					end
					OP_GET, OP_DEL, OP_DEL_ALL: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					OP_EMPTY: begin
						cmd.clear_all = 1'b1;
						state_d       = S_RESP;
					end
					OP_CUR_RST: begin
						cmd.cur_reset = 1'b1;
						state_d       = S_RESP;
					end
					OP_NEXT: begin
						if (sts.cursor_ok) begin
							cmd.nx_rd = 1'b1;
							state_d   = S_NX_CAP;
						end else begin
							cmd.nx_miss = 1'b1;
							state_d     = S_RESP;
						end
					end
					default: begin
						state_d = S_RESP;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) begin
					state_d = (sts.op == OP_GET) ? S_RESP : S_RM_RD;
				end else if (sts.scan_done) begin
					cmd.scan_end = 1'b1;
					state_d      = S_RESP;
				end
			end
			S_RM_RD: begin
				cmd.rm_rd = 1'b1;
				state_d   = S_RM_WR;
			end
			S_RM_WR: begin
				// For delete-all, the entry moved in from the end is rechecked before the scan resumes.
				cmd.rm_wr = 1'b1;
				if (sts.op == OP_DEL) begin
					state_d = S_RESP;
				end else if (sts.mv_match) begin
					state_d = S_RM_RD;
				end else begin
					cmd.scan_resume = 1'b1;
					state_d         = S_SCAN;
				end
			end
			S_NX_CAP: begin
				cmd.nx_cap = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/uale_dp.sv =====
// ----------------------------------------------------------------------------
// uale_dp
// List datapath: entry RAM, count and cursor, the pipelined key scan and the
// result and response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module uale_dp
	import uale_pkg::*;
#(
	parameter int CAPACITY     = 64,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32,
	parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic [2:0]              mode,
	input  wire logic [KEY_BITS-1:0]     key,
	input  wire logic [PAYLOAD_BITS-1:0] payload,
	output logic                         found,
	output logic [KEY_BITS-1:0]          item_key,
	output logic [PAYLOAD_BITS-1:0]      item_payload,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         is_full,
	output logic [1:0]                   status
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int W     = KEY_BITS + PAYLOAD_BITS;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	op_t                     op_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        cursor_q;
	logic [CNT_W-1:0]        idx_q;
	logic [IDX_W-1:0]        pidx_q;
	logic                    pv_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic                    found_q;
	status_t                 stat_q;
	logic [KEY_BITS-1:0]     rk_q;
	logic [PAYLOAD_BITS-1:0] rp_q;

	logic                    we, re;
	logic [IDX_W-1:0]        waddr, raddr;
	logic [W-1:0]            wdata, rdata;
	logic [KEY_BITS-1:0]     rd_key;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic [CNT_W-1:0]        last_idx;
	logic [CNT_W-1:0]        hit_next;
	logic                    full;
	logic                    issue;
	logic                    hit;

	assign rd_key   = rdata[W-1:PAYLOAD_BITS];
	assign rd_pay   = rdata[PAYLOAD_BITS-1:0];
	assign last_idx = count_q - CNT_W'(1);
	assign hit_next = CNT_W'(hit_idx_q) + CNT_W'(1);
	assign full     = (count_q == CAP_C);
	// The scan issues one read per cycle; the compare sees the word in the cycle after the read.
	assign issue    = cmd.scan_step && (idx_q < count_q);
	assign hit      = pv_q && (rd_key == key_q);

	assign sts.op        = op_q;
	assign sts.cursor_ok = (cursor_q < count_q);
	assign sts.scan_hit  = hit;
	assign sts.scan_done = !pv_q && !(idx_q < count_q);
	assign sts.mv_match  = (rd_key == key_q) && (hit_next < count_q);

	always_comb begin
		re    = issue || cmd.rm_rd || cmd.nx_rd;
		raddr = idx_q[IDX_W-1:0];
		if (cmd.rm_rd) begin
			raddr = last_idx[IDX_W-1:0];
		end else if (cmd.nx_rd) begin
			raddr = cursor_q[IDX_W-1:0];
		end
		we    = (cmd.put && !full) || cmd.rm_wr;
		waddr = cmd.rm_wr ? hit_idx_q : count_q[IDX_W-1:0];
		wdata = cmd.rm_wr ? rdata : {key_q, pay_q};
	end

	uale_ram #(
		.WIDTH (W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			idx_q    <= '0;
			pv_q     <= 1'b0;
			found_q  <= 1'b0;
			stat_q   <= ST_OK;
		end else begin
			if (cmd.clear_all) begin
				count_q <= '0;
			end else if (cmd.put && !full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.rm_wr) begin
				count_q <= last_idx;
			end

			if (cmd.clear_all || cmd.cur_reset) begin
				cursor_q <= '0;
			end else if (cmd.nx_cap) begin
				cursor_q <= cursor_q + CNT_W'(1);
			end

			if (cmd.scan_init) begin
				idx_q <= '0;
				pv_q  <= 1'b0;
			end else if (cmd.scan_resume) begin
				idx_q <= hit_next;
				pv_q  <= 1'b0;
			end else if (cmd.scan_step) begin
				pv_q <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end

			if (cmd.start) begin
				found_q <= 1'b0;
				stat_q  <= ST_OK;
			end else if (cmd.put && full) begin
				stat_q <= ST_FULL;
			end else if ((cmd.scan_step && hit) || cmd.nx_cap) begin
				found_q <= 1'b1;
			end else if (cmd.scan_end && !found_q) begin
				stat_q <= ST_ABSENT;
			end else if (cmd.nx_miss) begin
				stat_q <= ST_PAST_END;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= op_t'(mode);
			key_q <= key;
			pay_q <= payload;
			rk_q  <= key;
			rp_q  <= payload;
		end
		if (cmd.scan_step) begin
			pidx_q <= idx_q[IDX_W-1:0];
			if (hit) begin
				hit_idx_q <= pidx_q;
				// Only the first match of the request is returned.
				if (!found_q) begin
					rk_q <= rd_key;
					rp_q <= rd_pay;
				end
			end
		end
		if (cmd.nx_cap) begin
			rk_q <= rd_key;
			rp_q <= rd_pay;
		end
		if (cmd.load_out) begin
			found        <= found_q;
			item_key     <= rk_q;
			item_payload <= rp_q;
			entry_count  <= count_q;
			is_full      <= full;
			status       <= stat_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/unsorted_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// unsorted_array_list_engine
// Fixed-capacity unsorted key/payload list with put, get, delete, delete-all,
// make-empty and a cursor walk; one response per request.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake   | Contents
//   --------+-----+-------------+---------------------------------------------
//   req     | in  | valid/ready | mode, key, payload
//   rsp     | out | valid/ready | found, item_key, item_payload, entry_count,
//           |     |             | is_full, status
//
// One request is worked on at a time. Put, make-empty and reset-cursor pass
// the execute state to the response register; next, with an entry left, also
// a capture state. Get is bounded by the scan of the entry RAM at one read
// port, one entry per cycle. After a match, delete moves the last entry into
// the freed slot; delete-all does so for each entry it removes, then resumes
// the scan. Reset clears the count and cursor at once; the RAM needs no
// clearing. A new request is taken while the previous response waits on rsp.
`default_nettype none

module unsorted_array_list_engine
	import uale_pkg::*;
#(
	parameter int CAPACITY     = 64,
	parameter int KEY_BITS     = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	uale_req_if.sink   req,
	uale_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cmd_t cmd;
	sts_t sts;

	uale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	uale_dp #(
		.CAPACITY     (CAPACITY),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.CNT_W        (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (req.mode),
		.key          (req.key),
		.payload      (req.payload),
		.found        (rsp.found),
		.item_key     (rsp.item_key),
		.item_payload (rsp.item_payload),
		.entry_count  (rsp.entry_count),
		.is_full      (rsp.is_full),
		.status       (rsp.status)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count above capacity");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> (rsp.status == ST_OK))
		else $error("entry returned with an error status");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_FULL)) |-> rsp.is_full)
		else $error("full status on a list that is not full");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in progress");

	a_scan_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && sts.scan_hit) |-> !sts.scan_done)
		else $error("scan reported a hit and exhaustion together");

endmodule

`default_nettype wire

// ===== verif/uale_list_checker.sv =====
// ----------------------------------------------------------------------------
// uale_list_checker
// Watches the request and response channels of the list engine, keeps its
// own copy of the list, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module uale_list_checker
	import uale_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	uale_req_if       req,
	uale_rsp_if       rsp,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        found;
		logic [15:0] item_key;
		logic [31:0] item_payload;
		logic [6:0]  entry_count;
		logic        is_full;
		status_t     status;
	} list_result_t;

	logic [15:0]  keys [CAPACITY];
	logic [31:0]  pays [CAPACITY];
	int           n_entries;
	int           walk_pos;
	list_result_t rsp_queue [$];
	list_result_t want;
	int           fail_count = 0;
	int           queue_depth = 0;

	assign errors  = fail_count;
	assign pending = queue_depth;

	// The last entry fills the hole left by the removed one.
	function automatic void drop_entry(input int idx);
		keys[idx] = keys[n_entries-1];
		pays[idx] = pays[n_entries-1];
		n_entries--;
	endfunction

	function automatic list_result_t list_apply(input logic [2:0] mode, input logic [15:0] k,
		input logic [31:0] p);
		list_result_t r;
		int           idx;
		r.found        = 1'b0;
		r.item_key     = k;
		r.item_payload = p;
		r.status       = ST_OK;
		case (mode)
			OP_PUT: begin
				if (n_entries >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					keys[n_entries] = k;
					pays[n_entries] = p;
					n_entries++;
				end
			end
			OP_GET, OP_DEL, OP_DEL_ALL: begin
				idx = 0;
				while (idx < n_entries && keys[idx] != k)
					idx++;
				if (idx >= n_entries) begin
					r.status = ST_ABSENT;
				end else begin
					r.found        = 1'b1;
					r.item_key     = keys[idx];
					r.item_payload = pays[idx];
					if (mode == OP_DEL) begin
						drop_entry(idx);
					end else if (mode == OP_DEL_ALL) begin
						// An entry moved into a freed slot must be checked again.
						while (idx < n_entries) begin
							if (keys[idx] == k)
								drop_entry(idx);
							else
								idx++;
						end
					end
				end
			end
			OP_EMPTY: begin
				n_entries = 0;
				walk_pos  = 0;
			end
			OP_CUR_RST: begin
				walk_pos = 0;
			end
			OP_NEXT: begin
				if (walk_pos < n_entries) begin
					r.found        = 1'b1;
					r.item_key     = keys[walk_pos];
					r.item_payload = pays[walk_pos];
					walk_pos++;
				end else begin
					r.status = ST_PAST_END;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = n_entries[6:0];
		r.is_full     = (n_entries == CAPACITY);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val, act_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_queue.delete();
			n_entries = 0;
			walk_pos  = 0;
			queue_depth <= 0;
		end else begin
			// A response always belongs to an earlier request, so it is checked first.
			if (rsp.valid && rsp.ready) begin
				if (rsp_queue.size() == 0) begin
					fail_count++;
					$display("%0t: response with no request outstanding: expected none, actual key %0h",
						$time, rsp.item_key);
				end else begin
					want = rsp_queue.pop_front();
					check_field("found", 32'(want.found), 32'(rsp.found));
					check_field("item_key", 32'(want.item_key), 32'(rsp.item_key));
					check_field("item_payload", want.item_payload, rsp.item_payload);
					check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
					check_field("is_full", 32'(want.is_full), 32'(rsp.is_full));
					check_field("status", 32'(want.status), 32'(rsp.status));
				end
			end
			if (req.valid && req.ready)
				rsp_queue.push_back(list_apply(req.mode, req.key, req.payload));
			queue_depth <= rsp_queue.size();
		end
	end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives the list engine with a directed sequence and then phases of random
// operations under random stalls on both channels; the checker predicts and
// compares each response and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
	import uale_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CAPACITY      = 64;
	localparam int          N_RANDOM_REQS = 1625;
	localparam int          HOLD_AT       = 300;
	localparam int          DRAIN_AT      = 800;
	localparam int          HOLD_CYCLES   = 400;
	localparam logic [2:0]  MODE_UNUSED   = 3'd7;

	typedef enum int {PR_FILL, PR_DRAIN, PR_WALK} profile_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	bit   hold_rsp = 1'b0;

	uale_req_if req_ch ();
	uale_rsp_if rsp_ch ();

	unsorted_array_list_engine #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	uale_list_checker #(
		.CAPACITY(CAPACITY)
	) i_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.errors (errors),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly back to back, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Small key pools make hits and duplicate keys common.
	function automatic logic [15:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 16'($urandom_range(0, 7));
		if (r < 75)
			return 16'hfff0 | 16'($urandom_range(0, 15));
		return 16'($urandom_range(0, 16'hffff));
	endfunction

	task automatic push_request(input logic [2:0] m, input logic [15:0] k, input logic [31:0] p,
		input int gap);
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= m;
		req_ch.key     <= k;
		req_ch.payload <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The extra edge lets the checker count the request accepted last.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Response side: random ready pattern, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_rsp && !hold_done) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: repeat ($urandom_range(1, 8)) @(posedge clk);
				7, 8:                repeat ($urandom_range(9, 40)) @(posedge clk);
				default:             repeat ($urandom_range(100, 300)) @(posedge clk);
			endcase
			if (pick_gap() > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int         issued;
		int         n;
		int         r;
		int         acc;
		int         phase_len;
		int         w [8];
		bit         burst;
		profile_t   prof;
		logic [2:0] m;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.mode    <= OP_PUT;
		req_ch.key     <= '0;
		req_ch.payload <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, key extremes, duplicate keys, walk, shrinking list.
		push_request(OP_NEXT, 16'h0007, 32'h0000_0001, pick_gap());
		push_request(OP_GET, 16'h0007, 32'h0000_0002, pick_gap());
		push_request(OP_DEL, 16'h0007, 32'h0000_0003, pick_gap());
		push_request(OP_DEL_ALL, 16'h0007, 32'h0000_0004, pick_gap());
		push_request(OP_PUT, 16'h0000, 32'h0000_0000, pick_gap());
		push_request(OP_PUT, 16'hffff, 32'hffff_ffff, pick_gap());
		push_request(OP_PUT, 16'h0005, 32'ha5a5_a5a5, pick_gap());
		push_request(OP_PUT, 16'h0005, 32'h5a5a_5a5a, pick_gap());
		push_request(OP_PUT, 16'h0000, 32'h1234_5678, pick_gap());
		push_request(OP_GET, 16'h0005, 32'h0, pick_gap());
		push_request(OP_GET, 16'h1234, 32'hdead_beef, pick_gap());
		push_request(OP_NEXT, 16'h0, 32'h0, pick_gap());
		push_request(OP_NEXT, 16'h0, 32'h0, pick_gap());
		push_request(OP_NEXT, 16'h0, 32'h0, pick_gap());
		push_request(OP_DEL, 16'h0000, 32'h0, pick_gap());
		push_request(OP_DEL_ALL, 16'h0005, 32'h0, pick_gap());
		// The cursor now sits beyond the shortened list.
		push_request(OP_NEXT, 16'h4321, 32'h8765_4321, pick_gap());
		push_request(OP_CUR_RST, 16'haaaa, 32'h5555_5555, pick_gap());
		push_request(OP_NEXT, 16'h0, 32'h0, pick_gap());
		push_request(MODE_UNUSED, 16'h5555, 32'haaaa_aaaa, pick_gap());
		push_request(OP_EMPTY, 16'h0f0f, 32'hf0f0_f0f0, pick_gap());
		push_request(OP_NEXT, 16'h0, 32'h0, pick_gap());
		push_request(OP_GET, 16'h0000, 32'h0, pick_gap());
		wait_drained();

		// A straight run of puts takes the list to capacity and past it.
		for (n = 0; n < CAPACITY + 2; n++)
			push_request(OP_PUT, pick_key(), $urandom, pick_gap());
		issued = CAPACITY + 2;

		while (issued < N_RANDOM_REQS) begin
			prof      = profile_t'($urandom_range(0, 2));
			burst     = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 80);
			// Weights in mode order: put, get, del, del_all, empty, cur_rst, next, unused.
			case (prof)
				PR_FILL:  w = '{60, 14, 6, 3, 1, 4, 10, 2};
				PR_DRAIN: w = '{18, 20, 25, 15, 3, 5, 12, 2};
				default:  w = '{15, 10, 10, 5, 2, 12, 45, 1};
			endcase
			for (n = 0; n < phase_len && issued < N_RANDOM_REQS; n++) begin
				r   = $urandom_range(0, 99);
				acc = 0;
				m   = OP_PUT;
				for (int i = 0; i < 8; i++) begin
					acc += w[i];
					if (r < acc) begin
						m = i[2:0];
						break;
					end
				end
				push_request(m, pick_key(), $urandom, burst ? 0 : pick_gap());
				issued++;
				if (issued == HOLD_AT)
					hold_rsp = 1'b1;
				if (issued == DRAIN_AT)
					wait_drained();
			end
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
